/* rtl/core/pts_pkg.sv */
// Shared types, codes and constants of the periodic task scheduler.
package pts_pkg;

  localparam int SLOT_LIMIT   = 16;
  localparam int SLOT_W       = 4;
  localparam int COUNT_W      = 5;
  localparam int TIME_W       = 32;
  localparam int SUM_W        = 36;
  localparam int LOAD_W       = 16;
  localparam int BETA_W       = 8;
  localparam int DVD_W        = TIME_W + 8;
  localparam int DIV_CNT_W    = 6;
  localparam int MAX_TASKS_DEF = 16;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam logic [BETA_W-1:0] BETA_RESET = 8'd243;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_DUE     = 2'd1;
  localparam logic [1:0] KIND_NOTHING = 2'd2;
  localparam logic [1:0] KIND_LOAD    = 2'd3;

  // register index (paddr[2]) of load_beta
  localparam logic REG_LOAD_BETA = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } table_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_EVAL,
    ST_FINISH,
    ST_DIV,
    ST_MIX,
    ST_SUM,
    ST_REPORT
  } state_t;

endpackage

/* rtl/core/pts_cmd_if.sv */
// Command channel: one beat per command.
interface pts_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [pts_pkg::TIME_W-1:0] period_us;
  logic [pts_pkg::TIME_W-1:0] now_us;
  logic [pts_pkg::TIME_W-1:0] elapsed_us;

  modport source (output valid, command, period_us, now_us, elapsed_us, input ready);
  modport sink   (input valid, command, period_us, now_us, elapsed_us, output ready);
endinterface

/* rtl/core/pts_res_if.sv */
// Result channel: one beat per result.
interface pts_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic                       accepted;
  logic [pts_pkg::SLOT_W-1:0] task_slot;
  logic [pts_pkg::LOAD_W-1:0] load_value;
  logic                       last;

  modport source (output valid, kind, accepted, task_slot, load_value, last, input ready);
  modport sink   (input valid, kind, accepted, task_slot, load_value, last, output ready);
endinterface

/* rtl/core/pts_table.sv */
// Task table: period and due time per slot, one write and one registered read port.
module pts_table (
  input  logic                       clk,
  input  pts_pkg::table_wr_t         wr,
  input  logic                       re,
  input  logic [pts_pkg::SLOT_W-1:0] raddr,
  output pts_pkg::entry_t            rdata
);

  pts_pkg::entry_t mem [pts_pkg::SLOT_LIMIT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pts_div.sv */
// Restoring divider, one quotient bit per cycle.
module pts_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pts_pkg::DVD_W-1:0] dividend,
  input  logic [pts_pkg::SUM_W-1:0] divisor,
  output logic                      done,
  output logic [pts_pkg::DVD_W-1:0] quotient
);

  logic                          busy;
  logic [pts_pkg::DIV_CNT_W-1:0] count;
  logic [pts_pkg::DVD_W-1:0]     dvd;
  logic [pts_pkg::SUM_W-1:0]     rem;
  logic [pts_pkg::SUM_W-1:0]     dsr;
  logic [pts_pkg::SUM_W:0]       rem_sh;
  logic [pts_pkg::SUM_W:0]       diff;
  logic                          ge;

  always_comb begin
    rem_sh = {rem, dvd[pts_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        dvd   <= dividend;
        dsr   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit drops out
        rem   <= ge ? diff[pts_pkg::SUM_W-1:0] : rem_sh[pts_pkg::SUM_W-1:0];
        dvd   <= {dvd[pts_pkg::DVD_W-2:0], ge};
        count <= count + 1'b1;
        if (count == pts_pkg::DIV_CNT_W'(pts_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

/* rtl/core/periodic_task_scheduler.sv */
// Periodic task scheduler: task table walk, load estimate and register port.
//
// cmd carries one command per beat (add task, tick with the current time,
// loop done with the measured time); res returns the results, the final
// result of each command marked by last. load_beta is written over the
// APB-style port at address 0 and reads back there.
// Add: one result. Tick: the table is read slot by slot, a read state then an
// evaluate state (read-modify-write) per occupied slot, then a finish state;
// each due slot gives one result and a tick with nothing due gives a single
// nothing-due result. Loop done: a serial divider and then the load blend
// (mix, sum) come before the load report; the report is made straight away
// when no interval has been summed.
// One command is worked on at a time; cmd.ready is high while idle, even
// with the last result still waiting in the output register.
// If res stalls, the walk waits with the result held steady.
// Reset empties the table, clears the interval sum and load, and sets
// load_beta to 243; table contents need no clearing.
module periodic_task_scheduler #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  pts_cmd_if.sink                     cmd,
  pts_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pts_pkg::PADDR_W-1:0] paddr,
  input  logic [pts_pkg::PDATA_W-1:0] pwdata,
  output logic [pts_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int Cap = (MAX_TASKS < pts_pkg::SLOT_LIMIT) ? MAX_TASKS : pts_pkg::SLOT_LIMIT;

  pts_pkg::state_t state, state_next;

  logic [pts_pkg::BETA_W-1:0]  load_beta;
  logic [pts_pkg::COUNT_W-1:0] task_count;
  logic [pts_pkg::SUM_W-1:0]   interval_sum;
  logic [pts_pkg::LOAD_W-1:0]  load_average;
  logic [pts_pkg::TIME_W-1:0]  interval_hold;
  logic [pts_pkg::TIME_W-1:0]  now_hold;
  logic [pts_pkg::COUNT_W-1:0] idx;
  logic                        pend_valid;
  logic [pts_pkg::SLOT_W-1:0]  pend_slot;
  logic [23:0]                 prod_a;
  logic [pts_pkg::LOAD_W-1:0]  ratio;

  logic                        out_valid;
  logic [1:0]                  out_kind;
  logic                        out_accepted;
  logic [pts_pkg::SLOT_W-1:0]  out_slot;
  logic [pts_pkg::LOAD_W-1:0]  out_load;
  logic                        out_last;

  logic                        cmd_acc;
  logic                        out_free;
  logic                        full;
  logic                        due;
  logic                        more;
  logic                        emit;
  logic [1:0]                  emit_kind;
  logic                        emit_accepted;
  logic [pts_pkg::SLOT_W-1:0]  emit_slot;
  logic                        emit_last;
  logic                        mem_re;
  pts_pkg::table_wr_t          wr;
  pts_pkg::entry_t             rdata;
  logic                        div_start;
  logic                        div_done;
  logic [pts_pkg::DVD_W-1:0]   quotient;
  logic [pts_pkg::SUM_W:0]     sum_add;
  logic [8:0]                  weight;
  logic [24:0]                 prod_b;
  logic [25:0]                 mix;
  logic                        cfg_wr;

  pts_table u_table (
    .clk   (clk),
    .wr    (wr),
    .re    (mem_re),
    .raddr (idx[pts_pkg::SLOT_W-1:0]),
    .rdata (rdata)
  );

  pts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({cmd.elapsed_us, 8'd0}),
    .divisor  (interval_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == pts_pkg::REG_LOAD_BETA) ?
                  pts_pkg::PDATA_W'(load_beta) : '0;

  assign cmd_acc  = cmd.valid && cmd.ready;
  assign out_free = !out_valid || res.ready;
  assign full     = task_count >= pts_pkg::COUNT_W'(Cap);
  assign due      = now_hold >= rdata.due;
  assign more     = idx < task_count;
  assign sum_add  = {1'b0, interval_sum} + (pts_pkg::SUM_W + 1)'(rdata.period);
  assign weight   = 9'd256 - {1'b0, load_beta};
  assign prod_b   = weight * ratio;
  assign mix      = {2'b00, prod_a} + {1'b0, prod_b} + 26'd128;

  always_comb begin
    state_next = state;
    unique case (state)
      pts_pkg::ST_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd.command)
            pts_pkg::CMD_ADD:  state_next = pts_pkg::ST_ADD;
            pts_pkg::CMD_TICK: state_next = pts_pkg::ST_READ;
            pts_pkg::CMD_DONE: state_next = (interval_sum != '0) ? pts_pkg::ST_DIV
                                                                 : pts_pkg::ST_REPORT;
            default:           state_next = pts_pkg::ST_IDLE;
          endcase
        end
      end
      pts_pkg::ST_ADD:    if (out_free) state_next = pts_pkg::ST_IDLE;
      pts_pkg::ST_READ:   state_next = more ? pts_pkg::ST_EVAL : pts_pkg::ST_FINISH;
      pts_pkg::ST_EVAL:   if (out_free) state_next = pts_pkg::ST_READ;
      pts_pkg::ST_FINISH: if (out_free) state_next = pts_pkg::ST_IDLE;
      pts_pkg::ST_DIV:    if (div_done) state_next = pts_pkg::ST_MIX;
      pts_pkg::ST_MIX:    state_next = pts_pkg::ST_SUM;
      pts_pkg::ST_SUM:    state_next = pts_pkg::ST_REPORT;
      pts_pkg::ST_REPORT: if (out_free) state_next = pts_pkg::ST_IDLE;
      default:            state_next = pts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready     = state == pts_pkg::ST_IDLE;
    mem_re        = (state == pts_pkg::ST_READ) && more;
    div_start     = (state == pts_pkg::ST_IDLE) && cmd_acc &&
                    (cmd.command == pts_pkg::CMD_DONE) && (interval_sum != '0);
    wr.en         = 1'b0;
    wr.addr       = idx[pts_pkg::SLOT_W-1:0];
    wr.data       = rdata;
    emit          = 1'b0;
    emit_kind     = pts_pkg::KIND_ADD;
    emit_accepted = 1'b0;
    emit_slot     = '0;
    emit_last     = 1'b1;
    unique case (state)
      pts_pkg::ST_ADD: begin
        emit          = out_free;
        emit_kind     = pts_pkg::KIND_ADD;
        emit_accepted = !full;
        emit_slot     = full ? '0 : task_count[pts_pkg::SLOT_W-1:0];
        wr.en         = out_free && !full;
        wr.addr       = task_count[pts_pkg::SLOT_W-1:0];
        wr.data       = '{period: interval_hold, due: '0};
      end
      pts_pkg::ST_EVAL: begin
        // an earlier due slot goes out once a later one shows it was not last
        emit        = out_free && due && pend_valid;
        emit_kind   = pts_pkg::KIND_DUE;
        emit_slot   = pend_slot;
        emit_last   = 1'b0;
        wr.en       = out_free && due;
        wr.data     = '{period: rdata.period, due: now_hold + rdata.period};
      end
      pts_pkg::ST_FINISH: begin
        emit      = out_free;
        emit_kind = pend_valid ? pts_pkg::KIND_DUE : pts_pkg::KIND_NOTHING;
        emit_slot = pend_valid ? pend_slot : '0;
      end
      pts_pkg::ST_REPORT: begin
        emit      = out_free;
        emit_kind = pts_pkg::KIND_LOAD;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pts_pkg::ST_IDLE;
      load_beta    <= pts_pkg::BETA_RESET;
      task_count   <= '0;
      interval_sum <= '0;
      load_average <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr && (paddr[2] == pts_pkg::REG_LOAD_BETA)) begin
        load_beta <= pwdata[pts_pkg::BETA_W-1:0];
      end

      if (cmd_acc) begin
        interval_hold <= cmd.period_us;
        now_hold      <= cmd.now_us;
        idx           <= '0;
        pend_valid    <= 1'b0;
      end

      if (state == pts_pkg::ST_ADD && out_free && !full) begin
        task_count <= task_count + 1'b1;
      end

      if (state == pts_pkg::ST_EVAL && out_free) begin
        idx <= idx + 1'b1;
        if (due) begin
          pend_valid <= 1'b1;
          pend_slot  <= idx[pts_pkg::SLOT_W-1:0];
          interval_sum <= sum_add[pts_pkg::SUM_W] ? '1 : sum_add[pts_pkg::SUM_W-1:0];
        end
      end

      if (state == pts_pkg::ST_MIX) begin
        prod_a <= load_beta * load_average;
        ratio  <= (quotient[pts_pkg::DVD_W-1:pts_pkg::LOAD_W] != '0) ? '1
                                                                    : quotient[pts_pkg::LOAD_W-1:0];
      end

      if (state == pts_pkg::ST_SUM) begin
        load_average <= (mix[25:24] != 2'b00) ? '1 : mix[23:8];
      end

      if (state == pts_pkg::ST_REPORT && out_free) begin
        interval_sum <= '0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind     <= emit_kind;
      out_accepted <= emit_accepted;
      out_slot     <= emit_slot;
      out_load     <= (emit_kind == pts_pkg::KIND_LOAD) ? load_average : '0;
      out_last     <= emit_last;
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_kind;
  assign res.accepted   = out_accepted;
  assign res.task_slot  = out_slot;
  assign res.load_value = out_load;
  assign res.last       = out_last;

endmodule
